// ----- rtl/fpd_pkg.sv -----
`default_nettype none
package fpd_pkg;

	localparam int IN_W          = 16;
	localparam int OUT_W         = 14;
	localparam int OUT_FRAC_BITS = 4;
	localparam int BREAK_W       = 15;
	localparam int CENTER_W      = 9;
	localparam int CENTERS_W     = 6 * CENTER_W;
	localparam int CFG_W         = CENTERS_W;
	localparam int MEMB_W        = 15;
	localparam int FULL_SCALE    = 25600;
	localparam int LABELS        = 7;

	// shared divider geometry: dividend, divisor and quotient widths
	localparam int DIV_NUM_W = 31;
	localparam int DIV_DEN_W = 17;
	localparam int DIV_Q_W   = 15;

	typedef logic signed [3:0] rule_lab_t;

	localparam rule_lab_t RULE_TABLE [LABELS][LABELS] = '{
		'{-4'sd6, -4'sd6, -4'sd6, -4'sd6, -4'sd5, -4'sd5, -4'sd4},
		'{-4'sd5, -4'sd5, -4'sd5, -4'sd4, -4'sd4, -4'sd3, -4'sd1},
		'{-4'sd4, -4'sd4, -4'sd3, -4'sd1,  4'sd0,  4'sd1,  4'sd2},
		'{-4'sd4, -4'sd3, -4'sd1,  4'sd0,  4'sd1,  4'sd3,  4'sd4},
		'{-4'sd2, -4'sd1,  4'sd0,  4'sd1,  4'sd3,  4'sd4,  4'sd4},
		'{ 4'sd1,  4'sd3,  4'sd4,  4'sd4,  4'sd5,  4'sd5,  4'sd5},
		'{ 4'sd4,  4'sd5,  4'sd5,  4'sd6,  4'sd6,  4'sd6,  4'sd6}
	};

	typedef enum logic [1:0] {
		MEMB_ZERO,
		MEMB_FULL,
		MEMB_DIV
	} memb_mode_t;

	typedef struct packed {
		logic signed [2:0] lab;
		memb_mode_t        mode;
	} fz_side_t;

	typedef struct packed {
		fz_side_t            side;
		logic [MEMB_W-1:0]   num;
		logic [MEMB_W-1:0]   den;
	} fz_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} out_side_t;

endpackage
`default_nettype wire

// ----- rtl/fuzzy_pd_controller.sv -----
`default_nettype none
// channel   ports                                  handshake
// ------    -----------------------------------    ------------------------------
// config    cfg_we, cfg_index, cfg_wdata           written when cfg_we is high
// input     error_value, error_rate                taken when start high, busy low
// result    drive_value                            shown for one cycle with done
//
// one item can be taken every cycle; busy never rises
// each result passes through the two 15-stage dividers
// (membership, then centroid) plus eight stages of fuzzify, rules and sums
// reset clears the valid bits and loads the default breakpoints and centres
// the receiver cannot stall, so the pipeline never holds
module fuzzy_pd_controller
	import fpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic signed [IN_W-1:0] error_value,
	input  wire logic signed [IN_W-1:0] error_rate,
	output logic                       done,
	output logic signed [OUT_W-1:0]    drive_value
);

	localparam logic [2:0] REG_ERR_ONE   = 3'd0;
	localparam logic [2:0] REG_ERR_TWO   = 3'd1;
	localparam logic [2:0] REG_ERR_THREE = 3'd2;
	localparam logic [2:0] REG_RATE_ONE  = 3'd3;
	localparam logic [2:0] REG_RATE_TWO  = 3'd4;
	localparam logic [2:0] REG_RATE_THREE = 3'd5;
	localparam logic [2:0] REG_CENTERS   = 3'd6;

	logic [BREAK_W-1:0]   err_b1_q, err_b2_q, err_b3_q;
	logic [BREAK_W-1:0]   rate_b1_q, rate_b2_q, rate_b3_q;
	logic [CENTERS_W-1:0] centers_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_b1_q  <= BREAK_W'(20);
			err_b2_q  <= BREAK_W'(40);
			err_b3_q  <= BREAK_W'(60);
			rate_b1_q <= BREAK_W'(15);
			rate_b2_q <= BREAK_W'(30);
			rate_b3_q <= BREAK_W'(50);
			centers_q <= CENTERS_W'(54'd14097840970214450);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ERR_ONE:    err_b1_q  <= cfg_wdata[BREAK_W-1:0];
				REG_ERR_TWO:    err_b2_q  <= cfg_wdata[BREAK_W-1:0];
				REG_ERR_THREE:  err_b3_q  <= cfg_wdata[BREAK_W-1:0];
				REG_RATE_ONE:   rate_b1_q <= cfg_wdata[BREAK_W-1:0];
				REG_RATE_TWO:   rate_b2_q <= cfg_wdata[BREAK_W-1:0];
				REG_RATE_THREE: rate_b3_q <= cfg_wdata[BREAK_W-1:0];
				REG_CENTERS:    centers_q <= cfg_wdata[CENTERS_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	function automatic fz_t fuzzify(input logic signed [IN_W-1:0] x,
			input logic [BREAK_W-1:0] b1, input logic [BREAK_W-1:0] b2,
			input logic [BREAK_W-1:0] b3);
		logic signed [17:0] xs, p1, p2, p3, lnum, lden;
		fz_t r;
		xs   = 18'(x);
		p1   = 18'(b1);
		p2   = 18'(b2);
		p3   = 18'(b3);
		r    = '0;
		lnum = '0;
		lden = '0;
		if (xs > -p3 && xs < p3) begin
			if (xs <= -p2) begin
				r.side.lab = -3'sd2; lnum = -p2 - xs; lden = p3 - p2;
			end else if (xs <= -p1) begin
				r.side.lab = -3'sd1; lnum = -p1 - xs; lden = p2 - p1;
			end else if (xs <= 18'sd0) begin
				r.side.lab = 3'sd0; lnum = -xs; lden = p1;
			end else if (xs <= p1) begin
				r.side.lab = 3'sd1; lnum = p1 - xs; lden = p1;
			end else if (xs <= p2) begin
				r.side.lab = 3'sd2; lnum = p2 - xs; lden = p2 - p1;
			end else begin
				r.side.lab = 3'sd3; lnum = p3 - xs; lden = p3 - p2;
			end
			if (lden <= 18'sd0 || lnum <= 18'sd0)
				r.side.mode = MEMB_ZERO;
			else if (lnum >= lden)
				r.side.mode = MEMB_FULL;
			else
				r.side.mode = MEMB_DIV;
			r.num = lnum[MEMB_W-1:0];
			r.den = lden[MEMB_W-1:0];
		end else if (xs <= -p3) begin
			r.side.lab  = -3'sd2;
			r.side.mode = MEMB_FULL;
		end else begin
			r.side.lab  = 3'sd3;
			r.side.mode = MEMB_ZERO;
		end
		return r;
	endfunction

	function automatic logic signed [CENTER_W:0] center_of(input rule_lab_t lab,
			input logic [CENTERS_W-1:0] cs);
		logic [2:0]                mag;
		logic signed [CENTER_W:0] c;
		mag = lab[3] ? 3'(-lab) : lab[2:0];
		case (mag)
			3'd1:    c = (CENTER_W+1)'(cs[0*CENTER_W +: CENTER_W]);
			3'd2:    c = (CENTER_W+1)'(cs[1*CENTER_W +: CENTER_W]);
			3'd3:    c = (CENTER_W+1)'(cs[2*CENTER_W +: CENTER_W]);
			3'd4:    c = (CENTER_W+1)'(cs[3*CENTER_W +: CENTER_W]);
			3'd5:    c = (CENTER_W+1)'(cs[4*CENTER_W +: CENTER_W]);
			3'd6:    c = (CENTER_W+1)'(cs[5*CENTER_W +: CENTER_W]);
			default: c = '0;
		endcase
		return lab[3] ? -c : c;
	endfunction

	function automatic logic [MEMB_W-1:0] memb_of(input memb_mode_t mode,
			input logic [DIV_Q_W-1:0] q);
		logic [MEMB_W-1:0] m;
		case (mode)
			MEMB_ZERO: m = '0;
			MEMB_FULL: m = MEMB_W'(FULL_SCALE);
			default:   m = q[MEMB_W-1:0];
		endcase
		return m;
	endfunction

	// stage 1: pick the active labels and set up the membership fractions
	fz_t  fz_e_s1, fz_r_s1;
	logic v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		fz_e_s1 <= fuzzify(error_value, err_b1_q, err_b2_q, err_b3_q);
		fz_r_s1 <= fuzzify(error_rate, rate_b1_q, rate_b2_q, rate_b3_q);
	end

	// stage 2: scale the numerators to full scale
	logic [DIV_NUM_W-1:0] dvd_e_s2, dvd_r_s2;
	logic [DIV_DEN_W-1:0] dvs_e_s2, dvs_r_s2;
	fz_side_t             side_e_s2, side_r_s2;
	logic                 v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		dvd_e_s2  <= DIV_NUM_W'(30'(fz_e_s1.num) * 30'(FULL_SCALE));
		dvd_r_s2  <= DIV_NUM_W'(30'(fz_r_s1.num) * 30'(FULL_SCALE));
		dvs_e_s2  <= DIV_DEN_W'(fz_e_s1.den);
		dvs_r_s2  <= DIV_DEN_W'(fz_r_s1.den);
		side_e_s2 <= fz_e_s1.side;
		side_r_s2 <= fz_r_s1.side;
	end

	logic [DIV_Q_W-1:0] q_e, q_r;

	fpd_div u_div_err (
		.clk      (clk),
		.dividend (dvd_e_s2),
		.divisor  (dvs_e_s2),
		.quotient (q_e)
	);

	fpd_div u_div_rate (
		.clk      (clk),
		.dividend (dvd_r_s2),
		.divisor  (dvs_r_s2),
		.quotient (q_r)
	);

	// labels and valid ride alongside the membership dividers
	fz_side_t side_e_d [DIV_Q_W];
	fz_side_t side_r_d [DIV_Q_W];
	logic     vm_d     [DIV_Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_Q_W; i++)
				vm_d[i] <= 1'b0;
		end else begin
			vm_d[0] <= v_s2;
			for (int i = 1; i < DIV_Q_W; i++)
				vm_d[i] <= vm_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_e_d[0] <= side_e_s2;
		side_r_d[0] <= side_r_s2;
		for (int i = 1; i < DIV_Q_W; i++) begin
			side_e_d[i] <= side_e_d[i-1];
			side_r_d[i] <= side_r_d[i-1];
		end
	end

	// stage 3: rule lookup and min of memberships
	logic [MEMB_W-1:0] p0, p1, d0, d1;
	logic [2:0]        row0, row1, col0, col1;
	fz_side_t          se, sr;
	rule_lab_t         lab_s3 [4];
	logic [MEMB_W-1:0] w_s3   [4];
	logic              v_s3;

	always_comb begin
		se   = side_e_d[DIV_Q_W-1];
		sr   = side_r_d[DIV_Q_W-1];
		p0   = memb_of(se.mode, q_e);
		d0   = memb_of(sr.mode, q_r);
		p1   = MEMB_W'(FULL_SCALE) - p0;
		d1   = MEMB_W'(FULL_SCALE) - d0;
		row0 = 3'(se.lab) + 3'd2;
		row1 = 3'(se.lab) + 3'd3;
		col0 = 3'(sr.lab) + 3'd2;
		col1 = 3'(sr.lab) + 3'd3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= vm_d[DIV_Q_W-1];
	end

	always_ff @(posedge clk) begin
		lab_s3[0] <= RULE_TABLE[row0][col0];
		lab_s3[1] <= RULE_TABLE[row1][col0];
		lab_s3[2] <= RULE_TABLE[row0][col1];
		lab_s3[3] <= RULE_TABLE[row1][col1];
		w_s3[0]   <= (p0 <= d0) ? p0 : d0;
		w_s3[1]   <= (p1 <= d0) ? p1 : d0;
		w_s3[2]   <= (p0 <= d1) ? p0 : d1;
		w_s3[3]   <= (p1 <= d1) ? p1 : d1;
	end

	// stage 4: thin rules that share an output label, in fixed pair order
	logic [MEMB_W-1:0] wt [4];
	rule_lab_t         lab_s4 [4];
	logic [MEMB_W-1:0] w_s4   [4];
	logic              v_s4;

	always_comb begin
		for (int i = 0; i < 4; i++)
			wt[i] = w_s3[i];
		for (int i = 0; i < 3; i++) begin
			for (int j = i + 1; j < 4; j++) begin
				if (lab_s3[i] == lab_s3[j]) begin
					if (wt[i] > wt[j])
						wt[j] = '0;
					else
						wt[i] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			lab_s4[i] <= lab_s3[i];
			w_s4[i]   <= wt[i];
		end
	end

	// stage 5: weight times centre
	localparam int PROD_W = MEMB_W + CENTER_W + 2;
	localparam int SUM_W  = PROD_W + 2;

	logic signed [PROD_W-1:0] prod_s5 [4];
	logic [MEMB_W-1:0]        w_s5    [4];
	logic                     v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_s5[i] <= PROD_W'($signed({1'b0, w_s4[i]}))
				* PROD_W'(center_of(lab_s4[i], centers_q));
			w_s5[i]    <= w_s4[i];
		end
	end

	// stage 6: sums
	logic signed [SUM_W-1:0] num_s6;
	logic [DIV_DEN_W-1:0]    den_s6;
	logic                    v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		num_s6 <= SUM_W'(prod_s5[0]) + SUM_W'(prod_s5[1])
			+ SUM_W'(prod_s5[2]) + SUM_W'(prod_s5[3]);
		den_s6 <= DIV_DEN_W'(w_s5[0]) + DIV_DEN_W'(w_s5[1])
			+ DIV_DEN_W'(w_s5[2]) + DIV_DEN_W'(w_s5[3]);
	end

	// stage 7: sign and magnitude for the centroid divider
	logic [SUM_W-1:0]     mag;
	logic [DIV_NUM_W-1:0] dvd_s7;
	logic [DIV_DEN_W-1:0] dvs_s7;
	out_side_t            os_s7;
	logic                 v_s7;

	assign mag = num_s6[SUM_W-1] ? SUM_W'(-num_s6) : SUM_W'(num_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		dvd_s7    <= DIV_NUM_W'(mag) << OUT_FRAC_BITS;
		dvs_s7    <= den_s6;
		os_s7.neg  <= num_s6[SUM_W-1];
		os_s7.zero <= den_s6 == '0;
	end

	logic [DIV_Q_W-1:0] q_o;

	fpd_div u_div_out (
		.clk      (clk),
		.dividend (dvd_s7),
		.divisor  (dvs_s7),
		.quotient (q_o)
	);

	out_side_t os_d [DIV_Q_W];
	logic      vo_d [DIV_Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_Q_W; i++)
				vo_d[i] <= 1'b0;
		end else begin
			vo_d[0] <= v_s7;
			for (int i = 1; i < DIV_Q_W; i++)
				vo_d[i] <= vo_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		os_d[0] <= os_s7;
		for (int i = 1; i < DIV_Q_W; i++)
			os_d[i] <= os_d[i-1];
	end

	// output register, quotient truncated toward zero
	logic signed [OUT_W-1:0] res;
	logic                    done_q;
	logic signed [OUT_W-1:0] drive_q;

	always_comb begin
		if (os_d[DIV_Q_W-1].zero)
			res = '0;
		else if (os_d[DIV_Q_W-1].neg)
			res = OUT_W'(-q_o);
		else
			res = OUT_W'(q_o);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vo_d[DIV_Q_W-1];
	end

	always_ff @(posedge clk) begin
		drive_q <= res;
	end

	assign done        = done_q;
	assign drive_value = drive_q;

endmodule
`default_nettype wire

// ----- rtl/fpd_div.sv -----
`default_nettype none
module fpd_div
	import fpd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic [DIV_NUM_W-1:0] dividend,
	input  wire logic [DIV_DEN_W-1:0] divisor,
	output logic      [DIV_Q_W-1:0]   quotient
);

	logic [DIV_NUM_W-1:0] rem_s [DIV_Q_W];
	logic [DIV_DEN_W-1:0] dvs_s [DIV_Q_W];
	logic [DIV_Q_W-1:0]   q_s   [DIV_Q_W];

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
		logic [DIV_NUM_W-1:0] rin;
		logic [DIV_DEN_W-1:0] din;
		logic [DIV_Q_W-1:0]   qin;
		logic [DIV_NUM_W:0]   trial;
		logic                 ge;

		if (k == 0) begin : g_first
			assign rin = dividend;
			assign din = divisor;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign din = dvs_s[k-1];
			assign qin = q_s[k-1];
		end

		assign trial = (DIV_NUM_W+1)'(din) << (DIV_Q_W - 1 - k);
		assign ge    = {1'b0, rin} >= trial;

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? DIV_NUM_W'({1'b0, rin} - trial) : rin;
			dvs_s[k] <= din;
			q_s[k]   <= ge ? (qin | (DIV_Q_W'(1) << (DIV_Q_W - 1 - k))) : qin;
		end
	end

	assign quotient = q_s[DIV_Q_W-1];

endmodule
`default_nettype wire
